>>> rtl/core/xcfr_pkg.sv
// shared types and constants for the xor checked frame receiver
// used by every module under rtl/core
`default_nettype none

package xcfr_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;
    localparam int IDX_W  = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LIMIT = 2'd2;

    localparam logic [BYTE_W-1:0] RST_START_MARKER = 8'd170;
    localparam logic [BYTE_W-1:0] RST_END_MARKER   = 8'd85;
    localparam logic [LEN_W-1:0]  RST_LENGTH_LIMIT = 6'd32;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_CMD   = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHECK = 3'd4,
        PH_END   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_SHOW = 2'd2
    } t_bstate;

    typedef struct packed {
        logic              bank;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] cmd;
    } t_desc;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_done;

endpackage

`default_nettype wire

>>> rtl/core/xor_checked_frame_receiver_unit.sv
// xor checked frame receiver, top level
// depends on xcfr_pkg, xcfr_front, xcfr_queue, xcfr_back
//
// usage:
//   s_axis carries received bytes, one item per byte. frames are
//   start marker, command, length, payload, xor check, end marker.
//   m_axis carries results: one item per payload byte of a valid frame,
//   or one item for a zero-length frame; tlast marks the last of a frame.
//   cfg port (i_cfg_we, i_cfg_index, i_cfg_wdata) sets start marker,
//   end marker and length limit; write only while idle.
// flow:
//   the parser takes one byte per cycle. it holds s_axis_tready low on a
//   payload byte while both store banks still wait to be drained, and on
//   an end marker while the two-entry frame queue is full.
//   each result passes a store read, then the output register; the next
//   store read starts only once the shown result is taken, and each
//   frame's drain begins with a queue pop after its end marker is taken.
// reset: synchronous active-low; registers return to 170, 85, 32 and
//   the parser goes back to hunting. no clearing pass on the store.
// stall: a result holds on m_axis until m_axis_tready; the parser keeps
//   taking bytes of the next frame into the other bank.
`default_nettype none

module xor_checked_frame_receiver_unit #(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [xcfr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [xcfr_pkg::BYTE_W-1:0]       i_cfg_wdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [7:0] rx_byte
    input  wire logic [7:0]                        s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [7:0] command_code, [13:8] payload_length, [18:14] byte_index,
    // [26:19] payload_byte, [31:27] zero
    output logic [31:0]                            m_axis_tdata,
    output logic                                   m_axis_tlast
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic                        q_push;
    logic                        q_pop;
    logic                        q_empty;
    logic                        q_full;
    xcfr_pkg::t_desc             push_desc;
    xcfr_pkg::t_desc             head_desc;
    xcfr_pkg::t_done             done;
    logic                        wr_en;
    logic [AW:0]                 wr_addr;
    logic [xcfr_pkg::BYTE_W-1:0] wr_data;

    logic [xcfr_pkg::BYTE_W-1:0] command_code;
    logic [xcfr_pkg::LEN_W-1:0]  payload_length;
    logic [xcfr_pkg::IDX_W-1:0]  byte_index;
    logic [xcfr_pkg::BYTE_W-1:0] payload_byte;

    xcfr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .i_byte      (s_axis_tdata),
        .o_ready     (s_axis_tready),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_desc      (push_desc),
        .i_done      (done),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    xcfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (push_desc),
        .i_pop   (q_pop),
        .o_desc  (head_desc),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    xcfr_back #(
        .AW          (AW)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_wr_en          (wr_en),
        .i_wr_addr        (wr_addr),
        .i_wr_data        (wr_data),
        .i_q_empty        (q_empty),
        .i_desc           (head_desc),
        .o_pop            (q_pop),
        .o_done           (done),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_command_code   (command_code),
        .o_payload_length (payload_length),
        .o_byte_index     (byte_index),
        .o_payload_byte   (payload_byte),
        .o_last_of_run    (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b00000, payload_byte, byte_index, payload_length,
                           command_code};

endmodule

`default_nettype wire

>>> rtl/core/xcfr_queue.sv
// two-entry frame descriptor queue between parser and drain
// depends on xcfr_pkg
`default_nettype none

module xcfr_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire xcfr_pkg::t_desc i_desc,
    input  wire logic          i_pop,
    output xcfr_pkg::t_desc    o_desc,
    output logic               o_empty,
    output logic               o_full
);

    xcfr_pkg::t_desc r_mem [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= 2'(r_count + 2'd1);
            end else if (i_pop && !i_push) begin
                r_count <= 2'(r_count - 2'd1);
            end
        end
    end

    assign o_desc  = r_mem[r_rptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

endmodule

`default_nettype wire

>>> rtl/core/xcfr_front.sv
// byte parser: configuration registers, frame state machine, checksum,
// payload store writes and bank ownership; depends on xcfr_pkg
`default_nettype none

module xcfr_front #(
    parameter int MAX_PAYLOAD = 32,
    parameter int AW = 5
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [xcfr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [xcfr_pkg::BYTE_W-1:0]       i_cfg_wdata,
    input  wire logic                              i_valid,
    input  wire logic [xcfr_pkg::BYTE_W-1:0]       i_byte,
    output logic                                   o_ready,
    input  wire logic                              i_q_full,
    output logic                                   o_push,
    output xcfr_pkg::t_desc                        o_desc,
    input  wire xcfr_pkg::t_done                   i_done,
    output logic                                   o_wr_en,
    output logic [AW:0]                            o_wr_addr,
    output logic [xcfr_pkg::BYTE_W-1:0]            o_wr_data
);

    localparam logic [8:0] MAX_LEN = 9'(MAX_PAYLOAD);

    logic [xcfr_pkg::BYTE_W-1:0] r_start_marker;
    logic [xcfr_pkg::BYTE_W-1:0] r_end_marker;
    logic [xcfr_pkg::LEN_W-1:0]  r_length_limit;

    xcfr_pkg::t_phase            r_phase, n_phase;
    logic [xcfr_pkg::BYTE_W-1:0] r_cmd;
    logic [xcfr_pkg::LEN_W-1:0]  r_len;
    logic [xcfr_pkg::LEN_W-1:0]  r_fill;
    logic [xcfr_pkg::BYTE_W-1:0] r_run;
    logic [xcfr_pkg::BYTE_W-1:0] r_rcv;
    logic                        r_wbank;
    logic [1:0]                  r_busy;

    logic                        accept;
    logic                        len_ok;
    logic                        frame_ok;
    logic [xcfr_pkg::LEN_W-1:0]  fill_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= xcfr_pkg::RST_START_MARKER;
            r_end_marker   <= xcfr_pkg::RST_END_MARKER;
            r_length_limit <= xcfr_pkg::RST_LENGTH_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                xcfr_pkg::CFG_START_MARKER: r_start_marker <= i_cfg_wdata;
                xcfr_pkg::CFG_END_MARKER:   r_end_marker   <= i_cfg_wdata;
                xcfr_pkg::CFG_LENGTH_LIMIT:
                    r_length_limit <= i_cfg_wdata[xcfr_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign len_ok = ({1'b0, i_byte} <= {3'b000, r_length_limit}) &&
                    ({1'b0, i_byte} <= MAX_LEN);
    assign frame_ok  = (i_byte == r_end_marker) && (r_run == r_rcv);
    assign fill_next = xcfr_pkg::LEN_W'(r_fill + 1'b1);
    assign accept    = i_valid && o_ready;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (r_phase)
                xcfr_pkg::PH_CMD:  n_phase = xcfr_pkg::PH_LEN;
                xcfr_pkg::PH_LEN: begin
                    if (!len_ok) begin
                        n_phase = xcfr_pkg::PH_HUNT;
                    end else if (i_byte == 8'd0) begin
                        n_phase = xcfr_pkg::PH_CHECK;
                    end else begin
                        n_phase = xcfr_pkg::PH_DATA;
                    end
                end
                xcfr_pkg::PH_DATA: begin
                    if (fill_next >= r_len) begin
                        n_phase = xcfr_pkg::PH_CHECK;
                    end
                end
                xcfr_pkg::PH_CHECK: n_phase = xcfr_pkg::PH_END;
                xcfr_pkg::PH_END:   n_phase = xcfr_pkg::PH_HUNT;
                default: begin
                    n_phase = (i_byte == r_start_marker) ? xcfr_pkg::PH_CMD
                                                         : xcfr_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        o_ready   = 1'b1;
        o_push    = 1'b0;
        o_wr_en   = 1'b0;
        o_wr_addr = {r_wbank, r_fill[AW-1:0]};
        o_wr_data = i_byte;
        o_desc    = '{bank: r_wbank, len: r_len, cmd: r_cmd};
        unique case (r_phase)
            xcfr_pkg::PH_DATA: begin
                o_ready = !r_busy[r_wbank];
                o_wr_en = i_valid && !r_busy[r_wbank];
            end
            xcfr_pkg::PH_END: begin
                o_ready = !i_q_full;
                o_push  = i_valid && !i_q_full && frame_ok;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= xcfr_pkg::PH_HUNT;
            r_cmd   <= '0;
            r_len   <= '0;
            r_fill  <= '0;
            r_run   <= '0;
            r_rcv   <= '0;
            r_wbank <= 1'b0;
            r_busy  <= 2'b00;
        end else begin
            r_phase <= n_phase;
            if (i_done.valid) begin
                r_busy[i_done.bank] <= 1'b0;
            end
            if (o_push && (r_len != '0)) begin
                r_busy[r_wbank] <= 1'b1;
                r_wbank         <= ~r_wbank;
            end
            if (accept) begin
                unique case (r_phase)
                    xcfr_pkg::PH_CMD: begin
                        r_cmd <= i_byte;
                        r_run <= i_byte;
                    end
                    xcfr_pkg::PH_LEN: begin
                        if (len_ok) begin
                            r_len  <= i_byte[xcfr_pkg::LEN_W-1:0];
                            r_fill <= '0;
                            r_run  <= r_run ^ i_byte;
                        end
                    end
                    xcfr_pkg::PH_DATA: begin
                        r_run  <= r_run ^ i_byte;
                        r_fill <= fill_next;
                    end
                    xcfr_pkg::PH_CHECK: r_rcv <= i_byte;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/xcfr_back.sv
// result drain: payload store, store read and output register
// depends on xcfr_pkg
`default_nettype none

module xcfr_back #(
    parameter int AW = 5
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr_en,
    input  wire logic [AW:0]                   i_wr_addr,
    input  wire logic [xcfr_pkg::BYTE_W-1:0]   i_wr_data,
    input  wire logic                          i_q_empty,
    input  wire xcfr_pkg::t_desc               i_desc,
    output logic                               o_pop,
    output xcfr_pkg::t_done                    o_done,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [xcfr_pkg::BYTE_W-1:0]        o_command_code,
    output logic [xcfr_pkg::LEN_W-1:0]         o_payload_length,
    output logic [xcfr_pkg::IDX_W-1:0]         o_byte_index,
    output logic [xcfr_pkg::BYTE_W-1:0]        o_payload_byte,
    output logic                               o_last_of_run
);

    localparam int DEPTH = 2 * (2 ** AW);

    logic [xcfr_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [xcfr_pkg::BYTE_W-1:0] r_rd_data;

    xcfr_pkg::t_bstate           r_state, n_state;
    xcfr_pkg::t_desc             r_desc;
    logic [xcfr_pkg::LEN_W-1:0]  r_idx;
    logic                        rd_en;
    logic                        is_last;
    logic                        take;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[{r_desc.bank, r_idx[AW-1:0]}];
        end
    end

    assign is_last = (r_desc.len == '0) ||
                     (xcfr_pkg::LEN_W'(r_idx + 1'b1) == r_desc.len);
    assign take    = (r_state == xcfr_pkg::BK_SHOW) && i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            xcfr_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = xcfr_pkg::BK_READ;
                end
            end
            xcfr_pkg::BK_READ: n_state = xcfr_pkg::BK_SHOW;
            xcfr_pkg::BK_SHOW: begin
                if (i_ready) begin
                    n_state = is_last ? xcfr_pkg::BK_IDLE : xcfr_pkg::BK_READ;
                end
            end
            default: n_state = xcfr_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop        = (r_state == xcfr_pkg::BK_IDLE) && !i_q_empty;
        rd_en        = (r_state == xcfr_pkg::BK_READ);
        o_valid      = (r_state == xcfr_pkg::BK_SHOW);
        o_done.valid = take && is_last && (r_desc.len != '0);
        o_done.bank  = r_desc.bank;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xcfr_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_desc;
            r_idx  <= '0;
        end else if (take && !is_last) begin
            r_idx <= xcfr_pkg::LEN_W'(r_idx + 1'b1);
        end
    end

    assign o_command_code   = r_desc.cmd;
    assign o_payload_length = r_desc.len;
    assign o_byte_index     = r_idx[xcfr_pkg::IDX_W-1:0];
    assign o_payload_byte   = (r_desc.len == '0) ? '0 : r_rd_data;
    assign o_last_of_run    = is_last;

endmodule

`default_nettype wire
